### sv/wsi_pkg.sv
// Wilson score interval: shared widths, z constants, codes and stage types.
// No dependencies; wilson_score_interval_core imports this package.
package wsi_pkg;

  localparam int COUNT_BITS    = 32;
  localparam int FRACTION_BITS = 31;

  localparam int FIELD_W = 32;
  localparam int CW      = COUNT_BITS;
  localparam int FB      = FRACTION_BITS;
  localparam int ZW      = 34;                 // z at scale 2^32
  localparam int Z2W     = 35;                 // z^2 at scale 2^32
  localparam int QE      = FB + 1;             // quotient bits of estimate and centre
  localparam int DCW     = CW + 34;            // centre divisor
  localparam int TSH     = 64;                 // inner term scale
  localparam int QT      = CW - 2 + TSH;       // quotient bits of the inner term
  localparam int TW      = QT + 1;             // inner term plus z^2/4
  localparam int LA      = ((QT + 1) / 2 > QE) ? (QT + 1) / 2 : QE;
  localparam int SW      = (TW + 1) / 2;       // square-root bits
  localparam int SH      = (SW + 1) / 2;       // split of the root for the product
  localparam int PW      = ZW + SW;
  localparam int MN_SH   = (FB >= 32) ? FB - 32 : 0;
  localparam int MD_SH   = (FB >= 32) ? 0 : 32 - FB;
  localparam int NMW     = PW + MN_SH;
  localparam int DMW     = CW + 33 + MD_SH;    // margin divisor
  localparam int QM      = FB + 1;

  localparam logic [QE-1:0] ONE = {1'b1, {FB{1'b0}}};

  typedef enum logic [1:0] {
    ALPHA_10  = 2'd0,
    ALPHA_05  = 2'd1,
    ALPHA_01  = 2'd2,
    ALPHA_BAD = 2'd3
  } alpha_t;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_UNSUP  = 1'b1;
  localparam logic METHOD_NONE   = 1'b0;
  localparam logic METHOD_WILSON = 1'b1;

  localparam logic [ZW-1:0] Z_10 = 34'd7064592534;
  localparam logic [ZW-1:0] Z_05 = 34'd8417981215;
  localparam logic [ZW-1:0] Z_01 = 34'd11063102619;

  function automatic logic [Z2W-1:0] z2_calc(input logic [ZW-1:0] z);
    logic [2*ZW-1:0] p;
    p = (2*ZW)'(z) * (2*ZW)'(z) + (2*ZW)'(64'h8000_0000);
    return p[Z2W+31:32];
  endfunction

  localparam logic [Z2W-1:0] Z2_10 = z2_calc(Z_10);
  localparam logic [Z2W-1:0] Z2_05 = z2_calc(Z_05);
  localparam logic [Z2W-1:0] Z2_01 = z2_calc(Z_01);

  function automatic logic [ZW-1:0] z_of(input alpha_t code);
    logic [ZW-1:0] z;
    unique case (code)
      ALPHA_10: z = Z_10;
      ALPHA_05: z = Z_05;
      ALPHA_01: z = Z_01;
      default:  z = '0;
    endcase
    return z;
  endfunction

  function automatic logic [Z2W-1:0] z2_of(input alpha_t code);
    logic [Z2W-1:0] z2;
    unique case (code)
      ALPHA_10: z2 = Z2_10;
      ALPHA_05: z2 = Z2_05;
      ALPHA_01: z2 = Z2_01;
      default:  z2 = '0;
    endcase
    return z2;
  endfunction

  typedef struct packed {
    logic [CW-1:0] n;
    alpha_t        code;
  } side_t;

  typedef struct packed {
    logic [QE-1:0] est;
    logic [QE-1:0] ctr;
  } res_t;

  typedef struct packed {
    logic [CW-1:0] r;
    logic [QE-1:0] w;
  } ediv_t;

  typedef struct packed {
    logic [DCW-1:0] r;
    logic [QE-1:0]  w;
  } cdiv_t;

  typedef struct packed {
    logic [CW-1:0] r;
    logic [QT-1:0] w;
  } tdiv_t;

  typedef struct packed {
    logic [DMW-1:0] r;
    logic [QM-1:0]  w;
  } mdiv_t;

  typedef struct packed {
    logic [SW+1:0]   rm;
    logic [SW-1:0]   rt;
    logic [2*SW-1:0] tw;
  } sqrt_t;

endpackage

### sv/wsi_req_if.sv
// Request channel of the Wilson score interval block: valid, ready, payload.
// No dependencies.
interface wsi_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] success_count;
  logic [31:0] trial_total;
  logic [1:0]  alpha_code;

  modport source (output valid, success_count, trial_total, alpha_code, input ready);
  modport sink   (input valid, success_count, trial_total, alpha_code, output ready);
endinterface

### sv/wsi_res_if.sv
// Result channel of the Wilson score interval block: valid, ready, payload.
// No dependencies.
interface wsi_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] rate_estimate;
  logic [31:0] lower_bound;
  logic [31:0] upper_bound;
  logic [31:0] sample_size;
  logic [1:0]  alpha_echo;
  logic        method;

  modport source (output valid, status, rate_estimate, lower_bound, upper_bound,
                  sample_size, alpha_echo, method, input ready);
  modport sink   (input valid, status, rate_estimate, lower_bound, upper_bound,
                  sample_size, alpha_echo, method, output ready);
endinterface

### sv/wilson_score_interval_core.sv
// Wilson score interval core: pipelined dividers, square root and product.
// Depends on wsi_pkg, wsi_req_if and wsi_res_if.

// Each request (success count, trial total, confidence code) yields one result
// with the estimate k/n and the Wilson score bounds in unsigned Q1.31, clamped
// to [0,1]; a count above the total is taken as the total. While each result
// is taken, the pipeline takes one request per clock and delivers one result
// per clock. The stages are three entry stages, LA = 47 stages of the 94-step
// restoring division for k(n-k)/n (two steps per stage, the estimate and
// centre divisions running alongside), one stage adding z^2/4, SW = 48 stages
// of digit-by-digit square root, two stages for the z*sqrt product and QM = 32
// stages of margin division, then the output register. While a result waits
// on ready the whole pipe holds; the entry register still takes one request
// if it is empty. Code 3 reports unsupported with zeroed fields, and a zero
// total reports the interval [0,1], method none.
module wilson_score_interval_core (
  input  logic clk,
  input  logic rst,
  wsi_req_if.sink   request,
  wsi_res_if.source result
);
  import wsi_pkg::*;

  function automatic ediv_t est_step(input ediv_t s, input logic [CW-1:0] d);
    logic [CW:0] t;
    ediv_t o;
    t = {s.r, s.w[QE-1]};
    if (t >= {1'b0, d}) begin
      o.r = CW'(t - {1'b0, d});
      o.w = {s.w[QE-2:0], 1'b1};
    end else begin
      o.r = t[CW-1:0];
      o.w = {s.w[QE-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic cdiv_t cen_step(input cdiv_t s, input logic [DCW-1:0] d);
    logic [DCW:0] t;
    cdiv_t o;
    t = {s.r, s.w[QE-1]};
    if (t >= {1'b0, d}) begin
      o.r = DCW'(t - {1'b0, d});
      o.w = {s.w[QE-2:0], 1'b1};
    end else begin
      o.r = t[DCW-1:0];
      o.w = {s.w[QE-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic tdiv_t tot_step(input tdiv_t s, input logic [CW-1:0] d);
    logic [CW:0] t;
    tdiv_t o;
    t = {s.r, s.w[QT-1]};
    if (t >= {1'b0, d}) begin
      o.r = CW'(t - {1'b0, d});
      o.w = {s.w[QT-2:0], 1'b1};
    end else begin
      o.r = t[CW-1:0];
      o.w = {s.w[QT-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic mdiv_t mar_step(input mdiv_t s, input logic [DMW-1:0] d);
    logic [DMW:0] t;
    mdiv_t o;
    t = {s.r, s.w[QM-1]};
    if (t >= {1'b0, d}) begin
      o.r = DMW'(t - {1'b0, d});
      o.w = {s.w[QM-2:0], 1'b1};
    end else begin
      o.r = t[DMW-1:0];
      o.w = {s.w[QM-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [SW+3:0] t;
    logic [SW+3:0] trial;
    sqrt_t o;
    t     = {s.rm, s.tw[2*SW-1 -: 2]};
    trial = (SW+4)'({s.rt, 2'b01});
    o.tw  = {s.tw[2*SW-3:0], 2'b00};
    if (t >= trial) begin
      o.rm = (SW+2)'(t - trial);
      o.rt = {s.rt[SW-2:0], 1'b1};
    end else begin
      o.rm = t[SW+1:0];
      o.rt = {s.rt[SW-2:0], 1'b0};
    end
    return o;
  endfunction

  // Pipe advance: everything moves when the output register is free or taken.
  logic en;
  logic ld0;
  logic vo;
  logic v0;

  assign en  = !vo || result.ready;
  assign ld0 = !v0 || en;
  assign request.ready = ld0;

  // ---- entry stage: mask, saturate the count, hold the code
  logic [CW-1:0] k_in, n_in, k0, n0;
  alpha_t        c0;

  assign k_in = CW'(request.success_count);
  assign n_in = CW'(request.trial_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ld0) begin
      v0 <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      k0 <= (k_in > n_in) ? n_in : k_in;
      n0 <= n_in;
      c0 <= alpha_t'(request.alpha_code);
    end
  end

  // ---- stage 1: n - k
  logic          v1;
  logic [CW-1:0] k1, n1, nk1;
  alpha_t        c1;

  // ---- stage 2: k(n-k), centre numerator and divisor
  logic            v2;
  logic [2*CW-1:0] x2;
  logic [DCW-1:0]  a2, dc2;
  logic [CW-1:0]   k2, n2;
  alpha_t          c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1  <= k0;
      n1  <= n0;
      nk1 <= n0 - k0;
      c1  <= c0;
      x2  <= (2*CW)'(k1) * (2*CW)'(nk1);
      a2  <= (DCW'(k1) << 33) + DCW'(z2_of(c1));
      dc2 <= (DCW'(n1) << 33) + (DCW'(z2_of(c1)) << 1);
      k2  <= k1;
      n2  <= n1;
      c2  <= c1;
    end
  end

  // ---- phase A: estimate, centre and inner-term divisions
  ediv_t e_init;
  cdiv_t c_init;
  tdiv_t t_init;
  side_t s_init;

  assign e_init.r = k2 >> 1;
  assign e_init.w = {k2[0], {FB{1'b0}}};
  assign c_init.r = a2 >> 1;
  assign c_init.w = {a2[0], {FB{1'b0}}};
  assign t_init.r = CW'(x2 >> (CW - 2));
  assign t_init.w = {x2[CW-3:0], {TSH{1'b0}}};
  assign s_init.n    = n2;
  assign s_init.code = c2;

  logic           va  [LA];
  side_t          sa  [LA];
  ediv_t          ea  [LA];
  cdiv_t          ca  [LA];
  tdiv_t          ta  [LA];
  logic [DCW-1:0] dca [LA];

  for (genvar a = 0; a < LA; a++) begin : g_pa
    logic           v_in;
    side_t          s_in;
    ediv_t          e_in, e_out;
    cdiv_t          c_in, c_out;
    tdiv_t          t_in, t_mid, t_out;
    logic [DCW-1:0] dc_in;

    if (a == 0) begin : g_src
      assign v_in  = v2;
      assign s_in  = s_init;
      assign e_in  = e_init;
      assign c_in  = c_init;
      assign t_in  = t_init;
      assign dc_in = dc2;
    end else begin : g_src
      assign v_in  = va[a-1];
      assign s_in  = sa[a-1];
      assign e_in  = ea[a-1];
      assign c_in  = ca[a-1];
      assign t_in  = ta[a-1];
      assign dc_in = dca[a-1];
    end

    if (a < QE) begin : g_ec
      assign e_out = est_step(e_in, s_in.n);
      assign c_out = cen_step(c_in, dc_in);
    end else begin : g_ec
      assign e_out = e_in;
      assign c_out = c_in;
    end

    if (2 * a < QT) begin : g_t0
      assign t_mid = tot_step(t_in, s_in.n);
    end else begin : g_t0
      assign t_mid = t_in;
    end

    if (2 * a + 1 < QT) begin : g_t1
      assign t_out = tot_step(t_mid, s_in.n);
    end else begin : g_t1
      assign t_out = t_mid;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va[a] <= 1'b0;
      end else if (en) begin
        va[a] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa[a]  <= s_in;
        ea[a]  <= e_out;
        ca[a]  <= c_out;
        ta[a]  <= t_out;
        dca[a] <= dc_in;
      end
    end
  end

  // ---- add z^2/4 (z^2 at 2^32 shifted up by 30) to the inner term
  logic          vt;
  side_t         st;
  res_t          rt;
  logic [TW-1:0] tv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (en) begin
      vt <= va[LA-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st     <= sa[LA-1];
      rt.est <= ea[LA-1].w;
      rt.ctr <= ca[LA-1].w;
      tv     <= TW'(ta[LA-1].w) + (TW'(z2_of(sa[LA-1].code)) << 30);
    end
  end

  // ---- phase B: square root, one result bit per stage
  sqrt_t q_init;

  assign q_init.rm = '0;
  assign q_init.rt = '0;
  assign q_init.tw = (2*SW)'(tv);

  logic  vb [SW];
  side_t sb [SW];
  res_t  rb [SW];
  sqrt_t qb [SW];

  for (genvar b = 0; b < SW; b++) begin : g_pb
    logic  v_in;
    side_t s_in;
    res_t  r_in;
    sqrt_t q_in;

    if (b == 0) begin : g_src
      assign v_in = vt;
      assign s_in = st;
      assign r_in = rt;
      assign q_in = q_init;
    end else begin : g_src
      assign v_in = vb[b-1];
      assign s_in = sb[b-1];
      assign r_in = rb[b-1];
      assign q_in = qb[b-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vb[b] <= 1'b0;
      end else if (en) begin
        vb[b] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb[b] <= s_in;
        rb[b] <= r_in;
        qb[b] <= sqrt_step(q_in);
      end
    end
  end

  // ---- product z * sqrt in two halves, then sum; margin divisor alongside
  logic               vm0, vm1;
  side_t              sm0, sm1;
  res_t               rm0, rm1;
  logic [ZW+SH-1:0]   plo;
  logic [ZW+SW-SH-1:0] phi;
  logic [PW-1:0]      p1;
  logic [DMW-1:0]     dm0, dm1;
  logic [SW-1:0]      root;

  assign root = qb[SW-1].rt;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm0 <= 1'b0;
      vm1 <= 1'b0;
    end else if (en) begin
      vm0 <= vb[SW-1];
      vm1 <= vm0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm0 <= sb[SW-1];
      rm0 <= rb[SW-1];
      plo <= (ZW+SH)'(z_of(sb[SW-1].code)) * (ZW+SH)'(root[SH-1:0]);
      phi <= (ZW+SW-SH)'(z_of(sb[SW-1].code)) * (ZW+SW-SH)'(root[SW-1:SH]);
      dm0 <= DMW'((DMW'(sb[SW-1].n) << 32) + DMW'(z2_of(sb[SW-1].code))) << MD_SH;
      sm1 <= sm0;
      rm1 <= rm0;
      p1  <= PW'(plo) + (PW'(phi) << SH);
      dm1 <= dm0;
    end
  end

  // ---- phase D: margin division
  logic [NMW-1:0] m_num;
  mdiv_t          m_init;

  assign m_num    = NMW'(p1) << MN_SH;
  assign m_init.r = DMW'(m_num >> QM);
  assign m_init.w = m_num[QM-1:0];

  logic           vd  [QM];
  side_t          sd  [QM];
  res_t           rd  [QM];
  mdiv_t          md  [QM];
  logic [DMW-1:0] dmd [QM];

  for (genvar i = 0; i < QM; i++) begin : g_pd
    logic           v_in;
    side_t          s_in;
    res_t           r_in;
    mdiv_t          m_in;
    logic [DMW-1:0] d_in;

    if (i == 0) begin : g_src
      assign v_in = vm1;
      assign s_in = sm1;
      assign r_in = rm1;
      assign m_in = m_init;
      assign d_in = dm1;
    end else begin : g_src
      assign v_in = vd[i-1];
      assign s_in = sd[i-1];
      assign r_in = rd[i-1];
      assign m_in = md[i-1];
      assign d_in = dmd[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i] <= 1'b0;
      end else if (en) begin
        vd[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i]  <= s_in;
        rd[i]  <= r_in;
        md[i]  <= mar_step(m_in, d_in);
        dmd[i] <= d_in;
      end
    end
  end

  // ---- bounds, clamping and the special cases
  side_t       sl;
  res_t        rl;
  logic [QE-1:0] mg, lo, up, es;
  logic [QE:0]   up_sum;

  logic          status_next, method_next;
  logic [FIELD_W-1:0] est_next, lower_next, upper_next, size_next;

  assign sl     = sd[QM-1];
  assign rl     = rd[QM-1];
  assign mg     = md[QM-1].w;
  assign up_sum = {1'b0, rl.ctr} + {1'b0, mg};
  assign lo     = (rl.ctr > mg) ? rl.ctr - mg : '0;
  assign up     = (up_sum > {1'b0, ONE}) ? ONE : up_sum[QE-1:0];
  assign es     = (rl.est > ONE) ? ONE : rl.est;

  always_comb begin
    status_next = STATUS_OK;
    method_next = METHOD_NONE;
    est_next    = '0;
    lower_next  = '0;
    upper_next  = '0;
    size_next   = '0;
    priority if (sl.code == ALPHA_BAD) begin
      status_next = STATUS_UNSUP;
    end else if (sl.n == '0) begin
      // no data: the interval spans everything
      upper_next = FIELD_W'(ONE);
    end else begin
      method_next = METHOD_WILSON;
      est_next    = FIELD_W'(es);
      lower_next  = FIELD_W'(lo);
      upper_next  = FIELD_W'(up);
      size_next   = FIELD_W'(sl.n);
    end
  end

  logic               o_status, o_method;
  logic [FIELD_W-1:0] o_est, o_lower, o_upper, o_size;
  logic [1:0]         o_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vd[QM-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_status <= status_next;
      o_method <= method_next;
      o_est    <= est_next;
      o_lower  <= lower_next;
      o_upper  <= upper_next;
      o_size   <= size_next;
      o_alpha  <= sl.code;
    end
  end

  assign result.valid         = vo;
  assign result.status        = o_status;
  assign result.rate_estimate = o_est;
  assign result.lower_bound   = o_lower;
  assign result.upper_bound   = o_upper;
  assign result.sample_size   = o_size;
  assign result.alpha_echo    = o_alpha;
  assign result.method        = o_method;

`ifndef SYNTHESIS
  // the interval never inverts once computed
  a_order: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.method == METHOD_WILSON
      |-> result.lower_bound <= result.upper_bound)
    else $error("lower bound above upper bound");

  // clamp to one on estimate and upper bound
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.method == METHOD_WILSON
      |-> result.rate_estimate <= FIELD_W'(ONE) && result.upper_bound <= FIELD_W'(ONE))
    else $error("estimate or upper bound above one");

  // unsupported code zeroes the result fields
  a_unsup: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == STATUS_UNSUP
      |-> result.method == METHOD_NONE && result.rate_estimate == '0
          && result.sample_size == '0 && result.alpha_echo == ALPHA_BAD)
    else $error("unsupported code gave a populated result");

  // a computed interval carries a nonzero sample size
  a_size: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.method == METHOD_WILSON |-> result.sample_size != '0)
    else $error("computed interval with zero sample size");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid straight after reset");
`endif

endmodule
